### src/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg : shared types and constants for the relu/softmax activation unit
// Sequencer states, fixed-point constants and mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

    localparam logic MODE_RELU    = 1'b0;
    localparam logic MODE_SOFTMAX = 1'b1;

    localparam int VALUE_W  = 13;
    localparam int RESULT_W = 16;
    localparam int EXP_W    = 40;
    localparam int SUM_W    = 46;

    localparam logic [63:0]       Q62_ONE     = 64'h4000_0000_0000_0000;
    localparam logic [EXP_W-1:0]  EXP_SAT     = {EXP_W{1'b1}};
    localparam logic [RESULT_W-1:0] RESULT_SAT = {RESULT_W{1'b1}};
    localparam logic [4:0]        TAYLOR_LAST = 5'd30;
    localparam logic [2:0]        SQ_LAST     = 3'd4;
    localparam logic signed [11:0] P_START    = -12'sd62;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TERM_MUL,
        S_TERM_START,
        S_TERM_DIV,
        S_NORM,
        S_SQ_MUL,
        S_SQ_FIN,
        S_ROUND,
        S_EM_READ,
        S_EM_START,
        S_EM_DIV,
        S_EM_OUT
    } t_state;

endpackage

`default_nettype wire

### src/rsa_ifs.sv
// ----------------------------------------------------------------------------
// rsa_ifs : channel interfaces of the activation unit
// Input element, result and mode-write channels, each valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsa_in_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] value;
    logic               is_last;
    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface rsa_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] result;
    logic        end_of_run;
    modport source (output valid, output result, output end_of_run, input ready);
    modport sink   (input valid, input result, input end_of_run, output ready);
endinterface

interface rsa_cfg_if;
    logic valid;
    logic ready;
    logic mode;
    modport source (output valid, output mode, input ready);
    modport sink   (input valid, input mode, output ready);
endinterface

`default_nettype wire

### src/rsa_div.sv
// ----------------------------------------------------------------------------
// rsa_div : shared restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [63:0] i_dividend,
    input  wire  [45:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic [46:0] r_rem, n_rem;
    logic [63:0] r_dvd, n_dvd;
    logic [45:0] r_div, n_div;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [46:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem[45:0], r_dvd[63]};
    assign w_ge = (w_sh >= {1'b0, r_div});

    always_comb begin
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_div  = i_divisor;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift in one dividend bit, subtract where it fits
            n_rem = w_ge ? (w_sh - {1'b0, r_div}) : w_sh;
            n_dvd = {r_dvd[62:0], w_ge};
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

`default_nettype wire

### src/relu_softmax_activation_top.sv
// ----------------------------------------------------------------------------
// relu_softmax_activation_top : relu / softmax activation unit
// Sequenced datapath around one 32x32 multiplier and one shared divider.
// ----------------------------------------------------------------------------
//  channel    dir  payload               handshake
//  i_in_ch    in   value, is_last        valid/ready
//  o_out_ch   out  result, end_of_run    valid/ready, output register
//  i_cfg_ch   in   mode                  valid/ready, always ready
//
//  Relu: one transaction in, one result out, accepted while the sequencer
//  is idle and the output register is free. Softmax load: an element takes
//  up to 30 Taylor terms, each a multiply, a divider start and a divide,
//  plus normalisation, five squarings and a rounding step. Emission: each
//  stored element is read, divided by the sum in the shared divider and
//  sent out.
//  Reset is synchronous, active low; the store needs no clearing pass.
//  A stalled output holds the sequencer in its output step.
// ----------------------------------------------------------------------------
`default_nettype none

module relu_softmax_activation_top
    import rsa_pkg::*;
#(
    parameter int MAX_ELEMS = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rsa_in_if.sink     i_in_ch,
    rsa_out_if.source  o_out_ch,
    rsa_cfg_if.sink    i_cfg_ch
);

    localparam int ADDR_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ELEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMS);

    t_state r_state, n_state;

    logic                r_mode;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic                r_neg, n_neg;
    logic [12:0]         r_mag, n_mag;
    logic                r_last, n_last;
    logic [63:0]         r_series, n_series;
    logic [63:0]         r_term, n_term;
    logic [4:0]          r_k, n_k;
    logic [63:0]         r_m, n_m;
    logic signed [11:0]  r_p, n_p;
    logic [2:0]          r_sq, n_sq;
    logic [127:0]        r_acc, n_acc;
    logic [63:0]         r_prod;
    logic [1:0]          r_psh;
    logic [2:0]          r_pstep, n_pstep;
    logic [EXP_W-1:0]    r_rd;
    logic [RESULT_W-1:0] r_q, n_q;
    logic                r_ovalid, n_ovalid;
    logic [RESULT_W-1:0] r_ores, n_ores;
    logic                r_oeor, n_oeor;

    logic [EXP_W-1:0]    mem [MAX_ELEMS];

    // multiplier operands
    logic [31:0]  w_ma, w_mb;
    logic [1:0]   w_msh;
    logic [127:0] w_pext;

    logic         w_in_acc;
    logic         w_div_start, w_div_done;
    logic [63:0]  w_div_dvd, w_div_quot;
    logic [45:0]  w_div_dsr;
    logic [63:0]  w_series_upd;
    logic signed [11:0] w_s, w_p2;
    logic [5:0]   w_rsh;
    logic [63:0]  w_msh_val, w_rnd;
    logic [EXP_W-1:0] w_exp;
    logic [56:0]  w_num;

    assign w_in_acc      = i_in_ch.valid && i_in_ch.ready;
    assign i_in_ch.ready = (r_state == S_IDLE) && !r_ovalid;
    assign i_cfg_ch.ready = 1'b1;

    // select partial product: lo*lo, lo*hi, hi*lo, hi*hi for squaring
    always_comb begin
        if (r_state == S_TERM_MUL) begin
            w_ma  = r_pstep[0] ? r_term[63:32] : r_term[31:0];
            w_mb  = {19'd0, r_mag};
            w_msh = {1'b0, r_pstep[0]};
        end else begin
            w_ma  = r_pstep[1] ? r_m[63:32] : r_m[31:0];
            w_mb  = r_pstep[0] ? r_m[63:32] : r_m[31:0];
            w_msh = {1'b0, r_pstep[1] | r_pstep[0]} + {1'b0, r_pstep[1] & r_pstep[0]};
        end
    end

    always_comb begin
        case (r_psh)
            2'd0:    w_pext = {64'd0, r_prod};
            2'd1:    w_pext = {32'd0, r_prod, 32'd0};
            default: w_pext = {r_prod, 64'd0};
        endcase
    end

    // Taylor accumulate: odd terms subtract for negative arguments
    assign w_series_upd = (r_neg && r_k[0]) ? (r_series - w_div_quot)
                                            : (r_series + w_div_quot);

    // final rounding of the normalised mantissa to Q24.16
    assign w_p2      = (r_p <<< 1) + 12'sd64;
    assign w_s       = -(r_p + 12'sd16);
    assign w_rsh     = w_s[5:0] - 6'd1;
    assign w_msh_val = r_m >> w_rsh;
    assign w_rnd     = (w_msh_val >> 1) + {63'd0, w_msh_val[0]};

    always_comb begin
        if (w_s > 12'sd64)
            w_exp = '0;
        else if (w_s < 12'sd1)
            w_exp = EXP_SAT;
        else
            w_exp = w_rnd[EXP_W-1:0];
    end

    assign w_num = {1'b0, r_rd, 16'd0} + {12'd0, r_sum[SUM_W-1:1]};

    // shared divider requests
    always_comb begin
        w_div_start = 1'b0;
        w_div_dvd   = r_acc[76:13];
        w_div_dsr   = {41'd0, r_k};
        if (r_state == S_TERM_START) begin
            w_div_start = 1'b1;
        end else if (r_state == S_EM_START) begin
            w_div_start = (r_sum != '0);
            w_div_dvd   = {7'd0, w_num};
            w_div_dsr   = r_sum;
        end
    end

    rsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && r_mode == MODE_SOFTMAX)
                    n_state = S_TERM_MUL;
            end
            S_TERM_MUL: begin
                if (r_pstep == 3'd2)
                    n_state = S_TERM_START;
            end
            S_TERM_START: n_state = S_TERM_DIV;
            S_TERM_DIV: begin
                if (w_div_done) begin
                    if (w_div_quot == '0 || r_k == TAYLOR_LAST)
                        n_state = S_NORM;
                    else
                        n_state = S_TERM_MUL;
                end
            end
            S_NORM: begin
                if (r_m[63])
                    n_state = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                if (r_pstep == 3'd4)
                    n_state = S_SQ_FIN;
            end
            S_SQ_FIN: n_state = (r_sq == SQ_LAST) ? S_ROUND : S_SQ_MUL;
            S_ROUND: begin
                if (r_last || (r_count + 1'b1) == CNT_MAX)
                    n_state = S_EM_READ;
                else
                    n_state = S_IDLE;
            end
            S_EM_READ: n_state = S_EM_START;
            S_EM_START: n_state = (r_sum == '0) ? S_EM_OUT : S_EM_DIV;
            S_EM_DIV: begin
                if (w_div_done)
                    n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (!r_ovalid)
                    n_state = ((r_idx + 1'b1) == r_count) ? S_IDLE : S_EM_READ;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_count  = r_count;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_last   = r_last;
        n_series = r_series;
        n_term   = r_term;
        n_k      = r_k;
        n_m      = r_m;
        n_p      = r_p;
        n_sq     = r_sq;
        n_acc    = r_acc;
        n_pstep  = r_pstep;
        n_q      = r_q;
        n_ovalid = r_ovalid && !o_out_ch.ready;
        n_ores   = r_ores;
        n_oeor   = r_oeor;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_mode == MODE_RELU) begin
                        n_ovalid = 1'b1;
                        n_ores   = (!i_in_ch.value[12] && i_in_ch.value != '0)
                                   ? {3'd0, i_in_ch.value} : '0;
                        n_oeor   = 1'b1;
                    end else begin
                        n_neg    = i_in_ch.value[12];
                        n_mag    = i_in_ch.value[12] ? (~i_in_ch.value + 13'd1)
                                                     : i_in_ch.value;
                        n_last   = i_in_ch.is_last;
                        n_series = Q62_ONE;
                        n_term   = Q62_ONE;
                        n_k      = 5'd1;
                        n_sq     = '0;
                        n_pstep  = '0;
                    end
                end
            end
            S_TERM_MUL, S_SQ_MUL: begin
                // clear on first step, then add the previous partial product
                n_acc   = (r_pstep == '0) ? '0 : (r_acc + w_pext);
                n_pstep = r_pstep + 3'd1;
                if (n_state != r_state)
                    n_pstep = '0;
            end
            S_TERM_START: ;
            S_TERM_DIV: begin
                if (w_div_done) begin
                    if (w_div_quot != '0) begin
                        n_series = w_series_upd;
                        n_term   = w_div_quot;
                        n_k      = r_k + 5'd1;
                        n_m      = w_series_upd;
                    end else begin
                        n_m = r_series;
                    end
                    n_p = P_START;
                end
            end
            S_NORM: begin
                if (!r_m[63]) begin
                    n_m = r_m << 1;
                    n_p = r_p - 12'sd1;
                end
            end
            S_SQ_FIN: begin
                if (!r_acc[127]) begin
                    n_m = {r_acc[126:64], r_acc[63]};
                    n_p = w_p2 - 12'sd1;
                end else begin
                    n_m = r_acc[127:64];
                    n_p = w_p2;
                end
                n_sq = r_sq + 3'd1;
            end
            S_ROUND: begin
                n_sum   = r_sum + {{(SUM_W-EXP_W){1'b0}}, w_exp};
                n_count = r_count + 1'b1;
                n_idx   = '0;
            end
            S_EM_READ: ;
            S_EM_START: n_q = '0;
            S_EM_DIV: begin
                if (w_div_done)
                    n_q = (w_div_quot[63:16] != '0) ? RESULT_SAT : w_div_quot[15:0];
            end
            S_EM_OUT: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_q;
                    n_oeor   = ((r_idx + 1'b1) == r_count);
                    n_idx    = r_idx + 1'b1;
                    if ((r_idx + 1'b1) == r_count) begin
                        // vector done: drop count and sum
                        n_count = '0;
                        n_sum   = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_RELU;
            r_count  <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
            r_pstep  <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_ch.valid)
                r_mode <= i_cfg_ch.mode;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_ovalid <= n_ovalid;
            r_pstep  <= n_pstep;
            r_idx    <= n_idx;
        end
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_last   <= n_last;
        r_series <= n_series;
        r_term   <= n_term;
        r_k      <= n_k;
        r_m      <= n_m;
        r_p      <= n_p;
        r_sq     <= n_sq;
        r_acc    <= n_acc;
        r_prod   <= w_ma * w_mb;
        r_psh    <= w_msh;
        r_q      <= n_q;
        r_ores   <= n_ores;
        r_oeor   <= n_oeor;
    end

    // exponential store: written once per element, read once per result
    always_ff @(posedge i_clk) begin
        if (r_state == S_ROUND)
            mem[r_count[ADDR_W-1:0]] <= w_exp;
        r_rd <= mem[r_idx[ADDR_W-1:0]];
    end

    assign o_out_ch.valid      = r_ovalid;
    assign o_out_ch.result     = r_ores;
    assign o_out_ch.end_of_run = r_oeor;

endmodule

`default_nettype wire
